// ===== rtl/vcrl_pkg.sv =====
// Shared types, widths and reset values for the velocity command rate limiter.
// No dependencies; every other file imports this package.
`default_nettype none

package vcrl_pkg;

  // Velocity format, Q3.12 signed
  localparam int unsigned VEL_WIDTH = 16;
  localparam int unsigned FRAC_BITS = 12;

  // Register widths
  localparam int unsigned ACC_W      = 14;
  localparam int unsigned MAXLIN_W   = 13;
  localparam int unsigned MAXYAW_W   = 14;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // dv = acc/10 fits 11 bits, step = acc*dv >> FRAC_BITS fits 13 bits
  localparam int unsigned DV_W   = 11;
  localparam int unsigned STEP_W = 13;

  // acc/10 as multiply by reciprocal; exact for every 14-bit acc
  localparam int unsigned DIV10_W     = 16;
  localparam logic [DIV10_W-1:0] DIV10_MUL = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // Norm clamp datapath
  localparam int unsigned SQ_W   = 2 * VEL_WIDTH;
  localparam int unsigned ROOT_W = VEL_WIDTH;
  localparam int unsigned QUO_W  = VEL_WIDTH;
  localparam int unsigned NUM_W  = MAXLIN_W + VEL_WIDTH;

  // Output buffer
  localparam int unsigned OBUF_DEPTH = 2;
  localparam int unsigned OBUF_CNT_W = 2;

  localparam logic [ACC_W-1:0]    NORMAL_ACCEL_RST = 14'd4096;
  localparam logic [ACC_W-1:0]    STOP_ACCEL_RST   = 14'd8192;
  localparam logic [MAXLIN_W-1:0] MAX_LIN_RST      = 13'd4096;
  localparam logic [MAXYAW_W-1:0] MAX_YAW_RST      = 14'd4915;
  localparam logic [THR_W-1:0]    YAW_THR_RST      = 15'd205;
  localparam logic                YAW_EN_RST       = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_ACCEL = 3'd0,
    CFG_STOP_ACCEL   = 3'd1,
    CFG_MAX_LIN      = 3'd2,
    CFG_MAX_YAW      = 3'd3,
    CFG_YAW_THR      = 3'd4,
    CFG_YAW_EN       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ACC_W-1:0]    normal_accel;
    logic [ACC_W-1:0]    stop_accel;
    logic [MAXLIN_W-1:0] max_linear_speed;
    logic [MAXYAW_W-1:0] max_yaw_rate;
    logic [THR_W-1:0]    yaw_change_threshold;
    logic                yaw_limit_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] cmd_x;
    logic signed [VEL_WIDTH-1:0] cmd_y;
    logic signed [VEL_WIDTH-1:0] cmd_yaw;
    logic signed [VEL_WIDTH-1:0] meas_x;
    logic signed [VEL_WIDTH-1:0] meas_y;
    logic signed [VEL_WIDTH-1:0] meas_yaw;
    logic                        slowing;
  } in_beat_t;

  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] out_x;
    logic signed [VEL_WIDTH-1:0] out_y;
    logic signed [VEL_WIDTH-1:0] out_yaw;
  } out_beat_t;

  // Values that ride along the norm clamp pipeline
  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] ox;
    logic signed [VEL_WIDTH-1:0] oy;
    logic signed [VEL_WIDTH-1:0] oz;
    logic                        clamp;
    logic [NUM_W-1:0]            num_x;
    logic [NUM_W-1:0]            num_y;
  } lim_side_t;

  typedef struct packed {
    lim_side_t       side;
    logic [SQ_W-1:0] sq;
  } norm_beat_t;

  typedef struct packed {
    lim_side_t         side;
    logic [ROOT_W-1:0] root;
  } root_beat_t;

  // Magnitude of a signed velocity; -2^(W-1) maps to 2^(W-1)
  function automatic logic [VEL_WIDTH-1:0] vel_mag(input logic signed [VEL_WIDTH-1:0] v);
    logic signed [VEL_WIDTH:0] e;
    e = (VEL_WIDTH+1)'(v);
    if (e < 0) begin
      e = -e;
    end
    return e[VEL_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/velocity_command_rate_limiter_top.sv =====
// Path: an input beat passes through 6 slew/norm stages, 16 square-root stages and
// 16 divider stages, then the output buffer, before its result is presented.
// Throughput: one beat per cycle; a two-entry output buffer decouples the output stall,
// and the pipeline freezes only when that buffer is full.
// Reset: registers return to their defaults and the pipeline and buffer empty at once.
// Depends on vcrl_pkg, vcrl_slew, vcrl_sqrt, vcrl_div.
`default_nettype none

module velocity_command_rate_limiter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  vcrl_pkg::in_beat_t             in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output vcrl_pkg::out_beat_t            out_beat_o,
  input  logic                           cfg_we_i,
  input  logic [vcrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vcrl_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import vcrl_pkg::*;

  // Registers
  logic [ACC_W-1:0]    normal_q, stop_q;
  logic [MAXLIN_W-1:0] max_lin_q;
  logic [MAXYAW_W-1:0] max_yaw_q;
  logic [THR_W-1:0]    yaw_thr_q;
  logic                yaw_en_q;
  cfg_t                cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q  <= NORMAL_ACCEL_RST;
      stop_q    <= STOP_ACCEL_RST;
      max_lin_q <= MAX_LIN_RST;
      max_yaw_q <= MAX_YAW_RST;
      yaw_thr_q <= YAW_THR_RST;
      yaw_en_q  <= YAW_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NORMAL_ACCEL: normal_q  <= cfg_wdata_i[ACC_W-1:0];
        CFG_STOP_ACCEL:   stop_q    <= cfg_wdata_i[ACC_W-1:0];
        CFG_MAX_LIN:      max_lin_q <= cfg_wdata_i[MAXLIN_W-1:0];
        CFG_MAX_YAW:      max_yaw_q <= cfg_wdata_i[MAXYAW_W-1:0];
        CFG_YAW_THR:      yaw_thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_YAW_EN:       yaw_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.normal_accel         = normal_q;
  assign cfg.stop_accel           = stop_q;
  assign cfg.max_linear_speed     = max_lin_q;
  assign cfg.max_yaw_rate         = max_yaw_q;
  assign cfg.yaw_change_threshold = yaw_thr_q;
  assign cfg.yaw_limit_enable     = yaw_en_q;

  // Pipeline advances whenever the output buffer has room
  logic [OBUF_CNT_W-1:0] cnt_q, cnt_d;
  logic                  adv;
  logic                  push, pop;

  assign adv        = (cnt_q != OBUF_CNT_W'(OBUF_DEPTH));
  assign in_stall_o = !adv;

  logic       slew_valid, sqrt_valid, div_valid;
  norm_beat_t slew_beat;
  root_beat_t sqrt_beat;
  out_beat_t  div_beat;

  vcrl_slew u_slew (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .beat_i  (in_beat_i),
    .cfg_i   (cfg),
    .valid_o (slew_valid),
    .beat_o  (slew_beat)
  );

  vcrl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (slew_valid),
    .beat_i  (slew_beat),
    .valid_o (sqrt_valid),
    .beat_o  (sqrt_beat)
  );

  vcrl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sqrt_valid),
    .beat_i  (sqrt_beat),
    .valid_o (div_valid),
    .beat_o  (div_beat)
  );

  // Output buffer
  out_beat_t obuf_q [OBUF_DEPTH];
  logic      wr_q, rd_q;

  assign push = adv && div_valid;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      obuf_q[wr_q] <= div_beat;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_beat_o  = obuf_q[rd_q];

  a_obuf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OBUF_CNT_W'(OBUF_DEPTH))
    else $error("output buffer overflow");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == OBUF_CNT_W'(OBUF_DEPTH)) && out_stall_i) |=>
      (cnt_q == OBUF_CNT_W'(OBUF_DEPTH)))
    else $error("full output buffer changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/vcrl_slew.sv =====
// Front pipeline: acceleration pick, slew step, distance test, yaw clamp, norm squares.
// Six register stages; depends on vcrl_pkg.
`default_nettype none

module vcrl_slew (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  vcrl_pkg::in_beat_t   beat_i,
  input  vcrl_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output vcrl_pkg::norm_beat_t beat_o
);
  import vcrl_pkg::*;

  localparam int unsigned NSTG = 6;

  function automatic logic [VEL_WIDTH-1:0] absdiff(input logic signed [VEL_WIDTH-1:0] a,
                                                   input logic signed [VEL_WIDTH-1:0] b);
    logic signed [VEL_WIDTH:0] d;
    d = (VEL_WIDTH+1)'(a) - (VEL_WIDTH+1)'(b);
    if (d < 0) begin
      d = -d;
    end
    return d[VEL_WIDTH-1:0];
  endfunction

  // Move cur toward tgt by stp without passing tgt
  function automatic logic signed [VEL_WIDTH-1:0] project(
      input logic signed [VEL_WIDTH-1:0] cur,
      input logic signed [VEL_WIDTH-1:0] tgt,
      input logic [STEP_W-1:0]           stp);
    logic signed [VEL_WIDTH+1:0] cur_x;
    logic signed [VEL_WIDTH+1:0] tgt_x;
    logic signed [VEL_WIDTH+1:0] stp_x;
    logic signed [VEL_WIDTH+1:0] up;
    logic signed [VEL_WIDTH+1:0] dn;
    logic signed [VEL_WIDTH-1:0] res;
    cur_x = (VEL_WIDTH+2)'(cur);
    tgt_x = (VEL_WIDTH+2)'(tgt);
    stp_x = $signed((VEL_WIDTH+2)'(stp));
    up    = cur_x + stp_x;
    dn    = cur_x - stp_x;
    if (cur_x < tgt_x) begin
      res = (up < tgt_x) ? up[VEL_WIDTH-1:0] : tgt;
    end else begin
      res = (dn > tgt_x) ? dn[VEL_WIDTH-1:0] : tgt;
    end
    return res;
  endfunction

  logic [NSTG-1:0] v_q;

  // Stage 1
  logic [ACC_W-1:0]         acc_d, acc_q;
  logic [ACC_W+DIV10_W-1:0] dv_prod;
  logic [DV_W-1:0]          dv_d, dv_q;
  logic [VEL_WIDTH-1:0]     adx_d, adx_q, ady_d, ady_q;
  logic                     yaw_sw1_d, yaw_sw1_q;
  in_beat_t                 s1_q;

  // Stage 2
  logic [ACC_W+DV_W-1:0]    step_prod;
  logic [STEP_W-1:0]        step_d, step_q;
  logic [2*DV_W-1:0]        dvsq_d, dvsq_q, sqx_d, sqx_q, sqy_d, sqy_q;
  logic                     ge_d, ge_q;
  logic                     yaw_sw2_q;
  in_beat_t                 s2_q;

  // Stage 3
  logic                     far;
  logic signed [VEL_WIDTH-1:0] ox3_d, ox3_q, oy3_d, oy3_q, oz3_d, oz3_q;

  // Stage 4
  logic signed [VEL_WIDTH-1:0] ylim, nlim;
  logic signed [VEL_WIDTH-1:0] ox4_q, oy4_q, oz4_d, oz4_q;
  logic [VEL_WIDTH-1:0]        ax4_d, ax4_q, ay4_d, ay4_q;

  // Stage 5
  logic [SQ_W-1:0]             sqa5_d, sqa5_q, sqb5_d, sqb5_q;
  logic [2*MAXLIN_W-1:0]       maxsq5_d, maxsq5_q;
  logic [NUM_W-1:0]            numx5_d, numx5_q, numy5_d, numy5_q;
  logic signed [VEL_WIDTH-1:0] ox5_q, oy5_q, oz5_q;

  // Stage 6
  logic [SQ_W-1:0]             sq6_d;
  norm_beat_t                  out6_d, out6_q;

  always_comb begin
    acc_d     = beat_i.slowing ? cfg_i.stop_accel : cfg_i.normal_accel;
    dv_prod   = (ACC_W+DIV10_W)'(acc_d) * (ACC_W+DIV10_W)'(DIV10_MUL);
    dv_d      = dv_prod[DIV10_SHIFT +: DV_W];
    adx_d     = absdiff(beat_i.cmd_x, beat_i.meas_x);
    ady_d     = absdiff(beat_i.cmd_y, beat_i.meas_y);
    yaw_sw1_d = cfg_i.yaw_limit_enable &&
                (absdiff(beat_i.cmd_yaw, beat_i.meas_yaw) >
                 VEL_WIDTH'(cfg_i.yaw_change_threshold));
  end

  always_comb begin
    step_prod = (ACC_W+DV_W)'(acc_q) * (ACC_W+DV_W)'(dv_q);
    step_d    = step_prod[FRAC_BITS +: STEP_W];
    dvsq_d    = (2*DV_W)'(dv_q) * (2*DV_W)'(dv_q);
    // Only consulted when both diffs are below dv, so the low bits suffice
    sqx_d     = (2*DV_W)'(adx_q[DV_W-1:0]) * (2*DV_W)'(adx_q[DV_W-1:0]);
    sqy_d     = (2*DV_W)'(ady_q[DV_W-1:0]) * (2*DV_W)'(ady_q[DV_W-1:0]);
    ge_d      = (adx_q >= VEL_WIDTH'(dv_q)) || (ady_q >= VEL_WIDTH'(dv_q));
  end

  always_comb begin
    far   = ge_q ||
            (((2*DV_W+1)'(sqx_q) + (2*DV_W+1)'(sqy_q)) >= (2*DV_W+1)'(dvsq_q));
    ox3_d = far ? project(s2_q.meas_x, s2_q.cmd_x, step_q) : s2_q.cmd_x;
    oy3_d = far ? project(s2_q.meas_y, s2_q.cmd_y, step_q) : s2_q.cmd_y;
    oz3_d = yaw_sw2_q ? project(s2_q.meas_yaw, s2_q.cmd_yaw, step_q) : s2_q.cmd_yaw;
  end

  always_comb begin
    ylim = $signed(VEL_WIDTH'(cfg_i.max_yaw_rate));
    nlim = -ylim;
    if (oz3_q > ylim) begin
      oz4_d = ylim;
    end else if (oz3_q < nlim) begin
      oz4_d = nlim;
    end else begin
      oz4_d = oz3_q;
    end
    ax4_d = vel_mag(ox3_q);
    ay4_d = vel_mag(oy3_q);
  end

  always_comb begin
    sqa5_d   = SQ_W'(ax4_q) * SQ_W'(ax4_q);
    sqb5_d   = SQ_W'(ay4_q) * SQ_W'(ay4_q);
    maxsq5_d = (2*MAXLIN_W)'(cfg_i.max_linear_speed) *
               (2*MAXLIN_W)'(cfg_i.max_linear_speed);
    numx5_d  = NUM_W'(cfg_i.max_linear_speed) * NUM_W'(ax4_q);
    numy5_d  = NUM_W'(cfg_i.max_linear_speed) * NUM_W'(ay4_q);
  end

  always_comb begin
    sq6_d              = sqa5_q + sqb5_q;
    out6_d.sq          = sq6_d;
    out6_d.side.ox     = ox5_q;
    out6_d.side.oy     = oy5_q;
    out6_d.side.oz     = oz5_q;
    out6_d.side.clamp  = sq6_d > SQ_W'(maxsq5_q);
    out6_d.side.num_x  = numx5_q;
    out6_d.side.num_y  = numy5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q     <= acc_d;
      dv_q      <= dv_d;
      adx_q     <= adx_d;
      ady_q     <= ady_d;
      yaw_sw1_q <= yaw_sw1_d;
      s1_q      <= beat_i;

      step_q    <= step_d;
      dvsq_q    <= dvsq_d;
      sqx_q     <= sqx_d;
      sqy_q     <= sqy_d;
      ge_q      <= ge_d;
      yaw_sw2_q <= yaw_sw1_q;
      s2_q      <= s1_q;

      ox3_q     <= ox3_d;
      oy3_q     <= oy3_d;
      oz3_q     <= oz3_d;

      ox4_q     <= ox3_q;
      oy4_q     <= oy3_q;
      oz4_q     <= oz4_d;
      ax4_q     <= ax4_d;
      ay4_q     <= ay4_d;

      sqa5_q    <= sqa5_d;
      sqb5_q    <= sqb5_d;
      maxsq5_q  <= maxsq5_d;
      numx5_q   <= numx5_d;
      numy5_q   <= numy5_d;
      ox5_q     <= ox4_q;
      oy5_q     <= oy4_q;
      oz5_q     <= oz4_q;

      out6_q    <= out6_d;
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign beat_o  = out6_q;

endmodule

`default_nettype wire

// ===== rtl/vcrl_sqrt.sv =====
// Integer square root of the planar speed squared, one root bit per stage.
// ROOT_W register stages; depends on vcrl_pkg.
`default_nettype none

module vcrl_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  vcrl_pkg::norm_beat_t beat_i,
  output logic                 valid_o,
  output vcrl_pkg::root_beat_t beat_o
);
  import vcrl_pkg::*;

  localparam int unsigned SREM_W = ROOT_W + 4;
  localparam int unsigned LAST   = ROOT_W - 1;

  logic [ROOT_W-1:0] v_q;
  logic [SQ_W-1:0]   sq_q   [ROOT_W];
  logic [ROOT_W-1:0] r_q    [ROOT_W];
  logic [SREM_W-1:0] rem_q  [ROOT_W];
  lim_side_t         side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned PAIR = ROOT_W - 1 - k;

    logic [SQ_W-1:0]   sq_in;
    logic [ROOT_W-1:0] r_in, r_d;
    logic [SREM_W-1:0] rem_in, rem_sh, trial, rem_d;
    lim_side_t         side_in;

    if (k == 0) begin : g_head
      assign sq_in   = beat_i.sq;
      assign r_in    = '0;
      assign rem_in  = '0;
      assign side_in = beat_i.side;
    end else begin : g_body
      assign sq_in   = sq_q[k-1];
      assign r_in    = r_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_in[SREM_W-3:0], sq_in[2*PAIR +: 2]};
      trial  = SREM_W'({r_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        r_d   = {r_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        r_d   = {r_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sq_q[k]   <= sq_in;
        r_q[k]    <= r_d;
        rem_q[k]  <= rem_d;
        side_q[k] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[ROOT_W-2:0], valid_i};
    end
  end

  assign valid_o     = v_q[LAST];
  assign beat_o.side = side_q[LAST];
  assign beat_o.root = r_q[LAST];

  // Root and remainder reproduce the radicand, and the remainder stays within 2*root
  a_root_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAST] |->
      (((SQ_W+2)'(r_q[LAST]) * (SQ_W+2)'(r_q[LAST]) + (SQ_W+2)'(rem_q[LAST]))
         == (SQ_W+2)'(sq_q[LAST])) &&
      ((SQ_W+2)'(rem_q[LAST]) <= ((SQ_W+2)'(r_q[LAST]) << 1)))
    else $error("square root stage result inconsistent");

endmodule

`default_nettype wire

// ===== rtl/vcrl_div.sv =====
// Two-lane restoring divider for the norm clamp: max*|v| / root, one quotient bit per stage.
// QUO_W register stages plus the final sign and bypass select; depends on vcrl_pkg.
`default_nettype none

module vcrl_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  vcrl_pkg::root_beat_t beat_i,
  output logic                 valid_o,
  output vcrl_pkg::out_beat_t  beat_o
);
  import vcrl_pkg::*;

  localparam int unsigned DREM_W = ROOT_W + 1;
  localparam int unsigned LAST   = QUO_W - 1;

  function automatic logic [DREM_W+QUO_W-1:0] div_step(input logic [DREM_W-1:0] rem,
                                                       input logic [QUO_W-1:0]  quo,
                                                       input logic              bit_in,
                                                       input logic [ROOT_W-1:0] den);
    logic [DREM_W-1:0] sh;
    logic [DREM_W-1:0] dx;
    logic              ge;
    sh = {rem[DREM_W-2:0], bit_in};
    dx = DREM_W'(den);
    ge = sh >= dx;
    if (ge) begin
      sh = sh - dx;
    end
    return {sh, quo[QUO_W-2:0], ge};
  endfunction

  function automatic logic signed [VEL_WIDTH-1:0] apply_sign(input logic [QUO_W-1:0] q,
                                                             input logic neg);
    logic signed [VEL_WIDTH:0] e;
    e = $signed((VEL_WIDTH+1)'(q));
    if (neg) begin
      e = -e;
    end
    return e[VEL_WIDTH-1:0];
  endfunction

  logic [QUO_W-1:0]  v_q;
  logic [DREM_W-1:0] remx_q [QUO_W];
  logic [DREM_W-1:0] remy_q [QUO_W];
  logic [QUO_W-1:0]  qx_q   [QUO_W];
  logic [QUO_W-1:0]  qy_q   [QUO_W];
  logic [ROOT_W-1:0] root_q [QUO_W];
  lim_side_t         side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned BITI = QUO_W - 1 - k;

    logic [DREM_W-1:0] remx_in, remy_in;
    logic [QUO_W-1:0]  qx_in, qy_in;
    logic [ROOT_W-1:0] root_in;
    lim_side_t         side_in;
    logic [DREM_W+QUO_W-1:0] nx, ny;

    if (k == 0) begin : g_head
      // Upper numerator bits start the partial remainder
      assign remx_in = DREM_W'(beat_i.side.num_x[NUM_W-1:QUO_W]);
      assign remy_in = DREM_W'(beat_i.side.num_y[NUM_W-1:QUO_W]);
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign root_in = beat_i.root;
      assign side_in = beat_i.side;
    end else begin : g_body
      assign remx_in = remx_q[k-1];
      assign remy_in = remy_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign nx = div_step(remx_in, qx_in, side_in.num_x[BITI], root_in);
    assign ny = div_step(remy_in, qy_in, side_in.num_y[BITI], root_in);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        remx_q[k] <= nx[DREM_W+QUO_W-1:QUO_W];
        qx_q[k]   <= nx[QUO_W-1:0];
        remy_q[k] <= ny[DREM_W+QUO_W-1:QUO_W];
        qy_q[k]   <= ny[QUO_W-1:0];
        root_q[k] <= root_in;
        side_q[k] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[QUO_W-2:0], valid_i};
    end
  end

  lim_side_t side_l;
  assign side_l = side_q[LAST];

  assign valid_o        = v_q[LAST];
  assign beat_o.out_x   = side_l.clamp ? apply_sign(qx_q[LAST], side_l.ox < 0) : side_l.ox;
  assign beat_o.out_y   = side_l.clamp ? apply_sign(qy_q[LAST], side_l.oy < 0) : side_l.oy;
  assign beat_o.out_yaw = side_l.oz;

  // When clamping, the root is at least the limit, so no axis may grow
  a_clamp_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAST] && side_l.clamp) |->
      (qx_q[LAST] <= vel_mag(side_l.ox)) && (qy_q[LAST] <= vel_mag(side_l.oy)) &&
      (remx_q[LAST] < DREM_W'(root_q[LAST])) && (remy_q[LAST] < DREM_W'(root_q[LAST])))
    else $error("norm clamp quotient out of range");

endmodule

`default_nettype wire
